@@ src/sip_pkg.sv @@
// sip_pkg: shared constants and control struct for the segment intersection block
// no dependencies
`timescale 1ns / 1ps

package sip_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int POINT_BITS     = 24;

    // control that travels alongside each pair through the pipe
    typedef struct packed {
        logic vld;
        logic hit;
        logic zero;
        logic negx;
        logic negy;
    } t_ctl;

endpackage

@@ src/segment_intersection_point.sv @@
// segment_intersection_point: a pipeline made of the five front stages,
// one division cell per quotient bit and the output register
// throughput one pair per cycle; the whole pipe advances whenever the output is free or taken
// reset (synchronous, active low) clears only the valid bits of every stage
// top level: instantiates sip_front and a row of sip_div_cell; uses sip_pkg
`timescale 1ns / 1ps

module segment_intersection_point #(
    parameter int COORD_BITS = sip_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sip_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // cut_start_x, cut_start_y, cut_end_x, cut_end_y,
    // seg_start_x, seg_start_y, seg_end_x, seg_end_y
    input  logic [8*COORD_BITS-1:0]       i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // point_x, point_y
    output logic [2*sip_pkg::POINT_BITS-1:0] o_m_axis_tdata,
    // hit
    output logic                          o_m_axis_tuser
);
    import sip_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int Q  = COORD_BITS + FRAC_BITS;
    localparam int DW = 2 * COORD_BITS + 3;
    localparam int W  = Q + 2;
    localparam int WW = (W > POINT_BITS) ? W : POINT_BITS;

    logic en;
    assign en = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    t_ctl         ctl  [0:Q];
    logic [C-1:0] sx   [0:Q];
    logic [C-1:0] sy   [0:Q];
    logic [DW-1:0] den [0:Q];
    logic [DW-1:0] remx[0:Q];
    logic [DW-1:0] remy[0:Q];
    logic [Q-1:0] nx   [0:Q];
    logic [Q-1:0] ny   [0:Q];
    logic [Q-1:0] qx   [0:Q];
    logic [Q-1:0] qy   [0:Q];

    sip_front #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (i_s_axis_tvalid),
        .i_data (i_s_axis_tdata),
        .o_ctl  (ctl[0]),
        .o_sx   (sx[0]),
        .o_sy   (sy[0]),
        .o_den  (den[0]),
        .o_remx (remx[0]),
        .o_remy (remy[0]),
        .o_nx   (nx[0]),
        .o_ny   (ny[0])
    );

    assign qx[0] = '0;
    assign qy[0] = '0;

    for (genvar g = 0; g < Q; g++) begin : g_cell
        sip_div_cell #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_ctl  (ctl[g]),
            .i_sx   (sx[g]),
            .i_sy   (sy[g]),
            .i_den  (den[g]),
            .i_remx (remx[g]),
            .i_remy (remy[g]),
            .i_nx   (nx[g]),
            .i_ny   (ny[g]),
            .i_qx   (qx[g]),
            .i_qy   (qy[g]),
            .o_ctl  (ctl[g+1]),
            .o_sx   (sx[g+1]),
            .o_sy   (sy[g+1]),
            .o_den  (den[g+1]),
            .o_remx (remx[g+1]),
            .o_remy (remy[g+1]),
            .o_nx   (nx[g+1]),
            .o_ny   (ny[g+1]),
            .o_qx   (qx[g+1]),
            .o_qy   (qy[g+1])
        );
    end

    // final placement: start scaled up, plus or minus the truncated offset
    t_ctl                lc;
    logic signed [C-1:0] fsx, fsy;
    logic signed [W-1:0] bx, by, px, py;
    logic signed [WW-1:0] ex, ey;
    logic [POINT_BITS-1:0] n_px, n_py;

    always_comb begin
        lc  = ctl[Q];
        fsx = sx[Q];
        fsy = sy[Q];
        bx  = W'(fsx) <<< FRAC_BITS;
        by  = W'(fsy) <<< FRAC_BITS;
        if (lc.zero) begin
            px = bx;
            py = by;
        end else begin
            px = lc.negx ? bx - W'(qx[Q]) : bx + W'(qx[Q]);
            py = lc.negy ? by - W'(qy[Q]) : by + W'(qy[Q]);
        end
        ex   = WW'(px);
        ey   = WW'(py);
        n_px = lc.hit ? ex[POINT_BITS-1:0] : '0;
        n_py = lc.hit ? ey[POINT_BITS-1:0] : '0;
    end

    logic                  r_vld, r_hit;
    logic [POINT_BITS-1:0] r_px, r_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (en) begin
            r_vld <= lc.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit <= lc.hit;
            r_px  <= n_px;
            r_py  <= n_py;
        end
    end

    assign o_m_axis_tvalid = r_vld;
    assign o_m_axis_tuser  = r_hit;
    assign o_m_axis_tdata  = {r_py, r_px};

`ifndef SYNTHESIS
    // a rejected pair carries a zero point
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && !r_hit) |-> (o_m_axis_tdata == '0))
        else $error("rejected pair with nonzero point");

    // for a hit with two nonzero areas the last cell leaves a remainder below the denominator
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl[Q].vld && ctl[Q].hit && !ctl[Q].zero)
            |-> (remx[Q] < den[Q] && remy[Q] < den[Q]))
        else $error("division remainder out of range");

    // an output register is loaded only from a valid last cell
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && !ctl[Q].vld) |=> !o_m_axis_tvalid)
        else $error("output valid without a finished pair");
`endif

endmodule

@@ src/sip_front.sv @@
// sip_front: five-stage front end: differences, box and length rejects, cross products,
// side tests, areas and the numerators for the division chain; uses sip_pkg
`timescale 1ns / 1ps

module sip_front #(
    parameter int COORD_BITS = sip_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sip_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic [8*COORD_BITS-1:0]     i_data,
    output sip_pkg::t_ctl               o_ctl,
    output logic [COORD_BITS-1:0]       o_sx,
    output logic [COORD_BITS-1:0]       o_sy,
    output logic [2*COORD_BITS+2:0]     o_den,
    output logic [2*COORD_BITS+2:0]     o_remx,
    output logic [2*COORD_BITS+2:0]     o_remy,
    output logic [COORD_BITS+FRAC_BITS-1:0] o_nx,
    output logic [COORD_BITS+FRAC_BITS-1:0] o_ny
);
    import sip_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int Q  = COORD_BITS + FRAC_BITS;
    localparam int PW = 2 * C + 2;
    localparam int XW = 2 * C + 3;
    localparam int NW = (C + 1) + PW + FRAC_BITS;

    logic signed [C-1:0] cax, cay, cbx, cby, sax, say, sbx, sby;
    assign cax = i_data[0*C +: C];
    assign cay = i_data[1*C +: C];
    assign cbx = i_data[2*C +: C];
    assign cby = i_data[3*C +: C];
    assign sax = i_data[4*C +: C];
    assign say = i_data[5*C +: C];
    assign sbx = i_data[6*C +: C];
    assign sby = i_data[7*C +: C];

    // stage 1
    logic                r_v1, r_rej1;
    logic signed [C:0]   r_dsx, r_dsy, r_dcx, r_dcy, r_ox1, r_oy1, r_ox2, r_oy2, r_px2, r_py2;
    logic signed [C-1:0] r_sx1, r_sy1;
    logic signed [C-1:0] minc, maxc, mins, maxs, mincy, maxcy, minsy, maxsy;
    logic                n_rej1;

    always_comb begin
        minc  = (cax < cbx) ? cax : cbx;
        maxc  = (cax > cbx) ? cax : cbx;
        mins  = (sax < sbx) ? sax : sbx;
        maxs  = (sax > sbx) ? sax : sbx;
        mincy = (cay < cby) ? cay : cby;
        maxcy = (cay > cby) ? cay : cby;
        minsy = (say < sby) ? say : sby;
        maxsy = (say > sby) ? say : sby;
        n_rej1 = (minc >= maxs) || (maxc <= mins) || (mincy >= maxsy) || (maxcy <= minsy)
               || (cax == cbx && cay == cby) || (sax == sbx && say == sby);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rej1 <= n_rej1;
            r_dsx  <= (C+1)'(sbx) - (C+1)'(sax);
            r_dsy  <= (C+1)'(sby) - (C+1)'(say);
            r_dcx  <= (C+1)'(cbx) - (C+1)'(cax);
            r_dcy  <= (C+1)'(cby) - (C+1)'(cay);
            r_ox1  <= (C+1)'(cax) - (C+1)'(sax);
            r_oy1  <= (C+1)'(cay) - (C+1)'(say);
            r_ox2  <= (C+1)'(cbx) - (C+1)'(sax);
            r_oy2  <= (C+1)'(cby) - (C+1)'(say);
            r_px2  <= (C+1)'(sbx) - (C+1)'(cax);
            r_py2  <= (C+1)'(sby) - (C+1)'(cay);
            r_sx1  <= sax;
            r_sy1  <= say;
        end
    end

    // stage 2: eight products
    logic                 r_v2, r_rej2;
    logic signed [PW-1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5, r_p6, r_p7;
    logic signed [C:0]    r_dsx2, r_dsy2;
    logic signed [C-1:0]  r_sx2, r_sy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rej2 <= r_rej1;
            r_p0   <= r_ox1 * r_dsy;
            r_p1   <= r_oy1 * r_dsx;
            r_p2   <= r_ox2 * r_dsy;
            r_p3   <= r_oy2 * r_dsx;
            r_p4   <= r_ox1 * r_dcy;
            r_p5   <= r_oy1 * r_dcx;
            r_p6   <= r_px2 * r_dcy;
            r_p7   <= r_py2 * r_dcx;
            r_dsx2 <= r_dsx;
            r_dsy2 <= r_dsy;
            r_sx2  <= r_sx1;
            r_sy2  <= r_sy1;
        end
    end

    // stage 3: cross products and side tests
    logic                 r_v3, r_rej3;
    logic signed [XW-1:0] r_e1, r_e2;
    logic signed [C:0]    r_dsx3, r_dsy3;
    logic signed [C-1:0]  r_sx3, r_sy3;
    logic signed [XW-1:0] c1, c2, e1, e2;
    logic                 same_c, same_e;

    always_comb begin
        c1 = XW'(r_p0) - XW'(r_p1);
        c2 = XW'(r_p2) - XW'(r_p3);
        e1 = XW'(r_p5) - XW'(r_p4);
        e2 = XW'(r_p6) - XW'(r_p7);
        same_c = (c1 > 0 && c2 > 0) || (c1 < 0 && c2 < 0);
        same_e = (e1 > 0 && e2 > 0) || (e1 < 0 && e2 < 0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rej3 <= r_rej2 || same_c || same_e;
            r_e1   <= e1;
            r_e2   <= e2;
            r_dsx3 <= r_dsx2;
            r_dsy3 <= r_dsy2;
            r_sx3  <= r_sx2;
            r_sy3  <= r_sy2;
        end
    end

    // stage 4: areas, their sum and direction magnitudes
    logic                r_v4, r_rej4, r_zero4, r_negx4, r_negy4;
    logic [XW-1:0]       r_a1, r_den4;
    logic [C:0]          r_mx, r_my;
    logic signed [C-1:0] r_sx4, r_sy4;
    logic [XW-1:0]       a1, a2;

    always_comb begin
        a1 = r_e1[XW-1] ? XW'(-r_e1) : XW'(r_e1);
        a2 = r_e2[XW-1] ? XW'(-r_e2) : XW'(r_e2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rej4  <= r_rej3;
            r_zero4 <= (a1 == '0) || (a2 == '0);
            r_a1    <= a1;
            r_den4  <= a1 + a2;
            r_negx4 <= r_dsx3[C];
            r_negy4 <= r_dsy3[C];
            r_mx    <= r_dsx3[C] ? (C+1)'(-r_dsx3) : (C+1)'(r_dsx3);
            r_my    <= r_dsy3[C] ? (C+1)'(-r_dsy3) : (C+1)'(r_dsy3);
            r_sx4   <= r_sx3;
            r_sy4   <= r_sy3;
        end
    end

    // stage 5: numerators, split into starting remainder and the bits still to shift in
    logic [NW-1:0] nx, ny;

    always_comb begin
        nx = (NW'(r_mx) * NW'(r_a1)) << FRAC_BITS;
        ny = (NW'(r_my) * NW'(r_a1)) << FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl.vld <= 1'b0;
        end else if (i_en) begin
            o_ctl.vld <= r_v4;
        end
        if (i_en) begin
            o_ctl.hit  <= !r_rej4;
            o_ctl.zero <= r_zero4;
            o_ctl.negx <= r_negx4;
            o_ctl.negy <= r_negy4;
            o_sx       <= r_sx4;
            o_sy       <= r_sy4;
            o_den      <= r_den4;
            o_remx     <= XW'(nx >> Q);
            o_remy     <= XW'(ny >> Q);
            o_nx       <= nx[Q-1:0];
            o_ny       <= ny[Q-1:0];
        end
    end

endmodule

@@ src/sip_div_cell.sv @@
// sip_div_cell: one restoring-division step for the x and y quotients
// uses sip_pkg for the control struct
`timescale 1ns / 1ps

module sip_div_cell #(
    parameter int COORD_BITS = sip_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sip_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  sip_pkg::t_ctl                   i_ctl,
    input  logic [COORD_BITS-1:0]           i_sx,
    input  logic [COORD_BITS-1:0]           i_sy,
    input  logic [2*COORD_BITS+2:0]         i_den,
    input  logic [2*COORD_BITS+2:0]         i_remx,
    input  logic [2*COORD_BITS+2:0]         i_remy,
    input  logic [COORD_BITS+FRAC_BITS-1:0] i_nx,
    input  logic [COORD_BITS+FRAC_BITS-1:0] i_ny,
    input  logic [COORD_BITS+FRAC_BITS-1:0] i_qx,
    input  logic [COORD_BITS+FRAC_BITS-1:0] i_qy,
    output sip_pkg::t_ctl                   o_ctl,
    output logic [COORD_BITS-1:0]           o_sx,
    output logic [COORD_BITS-1:0]           o_sy,
    output logic [2*COORD_BITS+2:0]         o_den,
    output logic [2*COORD_BITS+2:0]         o_remx,
    output logic [2*COORD_BITS+2:0]         o_remy,
    output logic [COORD_BITS+FRAC_BITS-1:0] o_nx,
    output logic [COORD_BITS+FRAC_BITS-1:0] o_ny,
    output logic [COORD_BITS+FRAC_BITS-1:0] o_qx,
    output logic [COORD_BITS+FRAC_BITS-1:0] o_qy
);
    import sip_pkg::*;

    localparam int Q  = COORD_BITS + FRAC_BITS;
    localparam int DW = 2 * COORD_BITS + 3;

    logic [DW:0] tx, ty, dd;
    logic        gx, gy;

    always_comb begin
        dd = {1'b0, i_den};
        tx = {i_remx, i_nx[Q-1]};
        ty = {i_remy, i_ny[Q-1]};
        gx = (tx >= dd);
        gy = (ty >= dd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl.vld <= 1'b0;
        end else if (i_en) begin
            o_ctl.vld <= i_ctl.vld;
        end
        if (i_en) begin
            o_ctl.hit  <= i_ctl.hit;
            o_ctl.zero <= i_ctl.zero;
            o_ctl.negx <= i_ctl.negx;
            o_ctl.negy <= i_ctl.negy;
            o_sx       <= i_sx;
            o_sy       <= i_sy;
            o_den      <= i_den;
            o_remx     <= DW'(gx ? tx - dd : tx);
            o_remy     <= DW'(gy ? ty - dd : ty);
            o_nx       <= i_nx << 1;
            o_ny       <= i_ny << 1;
            o_qx       <= {i_qx[Q-2:0], gx};
            o_qy       <= {i_qy[Q-2:0], gy};
        end
    end

endmodule
